// File: rtl/cmc_pkg.sv
// ---------------------------------------------------------------------------
// cmc_pkg
// shared types and constants of the per-class mean and covariance engine
// ---------------------------------------------------------------------------
package cmc_pkg;

   localparam int MAX_DIM      = 16;
   localparam int DIM_W        = 4;
   localparam int SAMPLE_DEPTH = 4096;
   localparam int SAMPLE_AW    = 12;
   localparam int MAX_SAMPLES  = 1024;
   localparam int LABEL_AW     = 10;
   localparam int CNT_W        = 11;
   localparam int VAL_W        = 48;
   localparam int SUM_W        = 27;
   localparam int DEV_W        = 17;
   localparam int PROD_W       = 34;
   localparam int CFG_W        = 5;
   localparam int CSR_IDX_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CLASSES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSION = 2'd1;

   localparam logic KIND_MEAN = 1'b0;
   localparam logic KIND_COV  = 1'b1;

   typedef enum logic [1:0] {
      FUNC_ADD, FUNC_COMPUTE, FUNC_READ, FUNC_CLEAR
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK, STAT_FULL, STAT_RANGE, STAT_NOT_COMPUTED
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_READ, ST_CLS,
      ST_SLAB, ST_SCHK, ST_SRD, ST_SACC,
      ST_MGO, ST_MWAIT,
      ST_VLAB, ST_VCHK, ST_VRD, ST_VDEV, ST_VROW, ST_VMRD, ST_VMWR,
      ST_NRD, ST_NGO, ST_NWAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      func_type            func;
      logic [3:0]          sample_class;
      logic [3:0]          element_index;
      logic signed [15:0]  element_value;
      logic                last_element;
      logic                read_kind;
      logic [3:0]          read_class;
      logic [3:0]          read_row;
      logic [3:0]          read_col;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [CNT_W-1:0]        samples_in_class;
      status_type              status;
   } rsp_type;

endpackage

// File: rtl/classwise_mean_covariance.sv
// ---------------------------------------------------------------------------
// classwise_mean_covariance
// per-class sample mean and sample covariance engine
// ---------------------------------------------------------------------------
// usage
//   command channel: an item transfers at a clock edge with start high and
//   busy low. func selects add element, compute, read or clear.
//   result channel: every item gives one result, shown for one cycle with
//   rsp_valid high; the receiver cannot stall, so results never back up.
//   csr channel: csr_ready is always high; index 0 sets classes in use,
//   index 1 the vector dimension. write only while no item is in flight.
// operation
//   add and clear: result the cycle after the transfer, next item at once
//   read: registered ram read, then registered result; busy in the read state
//   compute: busy throughout; for each class in use it scans all stored
//     samples to sum the class and divides each mean element, then scans
//     them again for the deviations and the read-modify-write of the
//     covariance ram, then divides the covariance entries; one shared
//     serial divider (48 quotient bits) serves every division
// reset
//   synchronous; empties the store, zeroes class counts, marks results not
//   computed; ram contents are not cleared and need not be
// ---------------------------------------------------------------------------
module classwise_mean_covariance
   import cmc_pkg::*;
#(
   parameter int MAX_CLASSES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   // class labels are four bits wide, so no more than sixteen are reachable
   localparam int NCLS    = (MAX_CLASSES < MAX_DIM) ? MAX_CLASSES : MAX_DIM;
   localparam int CIDX_W  = (NCLS > 1) ? $clog2(NCLS) : 1;
   localparam int MEAN_AW = CIDX_W + DIM_W;
   localparam int COV_AW  = CIDX_W + 2 * DIM_W;
   localparam logic [CFG_W-1:0] NCLS_K = CFG_W'(NCLS);
   localparam logic [CFG_W-1:0] DIM_K  = CFG_W'(MAX_DIM);
   localparam logic [5:0] DIV_STEPS = 6'(VAL_W - 1);

   // ---------------- configuration ----------------
   logic [CFG_W-1:0] cfg_k_ff, cfg_d_ff;
   logic [CFG_W-1:0] eff_k, eff_d;
   logic [DIM_W-1:0] d_last;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_k_ff <= CFG_W'(4);
         cfg_d_ff <= CFG_W'(4);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_CLASSES) begin
            cfg_k_ff <= csr_wdata;
         end else if (csr_index == CSR_DIMENSION) begin
            cfg_d_ff <= csr_wdata;
         end
      end
   end

   // zero acts as one, large values clamp to what is built
   assign eff_k  = (cfg_k_ff == '0) ? CFG_W'(1) : ((cfg_k_ff > NCLS_K) ? NCLS_K : cfg_k_ff);
   assign eff_d  = (cfg_d_ff == '0) ? CFG_W'(1) : ((cfg_d_ff > DIM_K) ? DIM_K : cfg_d_ff);
   assign d_last = DIM_W'(eff_d - CFG_W'(1));

   // ---------------- state ----------------
   state_type state_ff, state_in;
   logic [CNT_W-1:0]       sample_total_ff;
   logic [CNT_W-1:0]       counts_ff [NCLS];
   logic                   results_valid_ff;
   logic [CIDX_W-1:0]      c_ff;
   logic [CNT_W-1:0]       s_ff;
   logic [SAMPLE_AW-1:0]   base_ff;
   logic [DIM_W-1:0]       j_ff, m_ff;
   logic                   first_ff;
   logic signed [SUM_W-1:0]  sums_ff   [MAX_DIM];
   logic signed [15:0]       mean_r_ff [MAX_DIM];
   logic signed [DEV_W-1:0]  dev_ff    [MAX_DIM];
   logic signed [DEV_W-1:0]  devj_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                   rd_kind_ff;
   status_type             rd_stat_ff;
   logic [CNT_W-1:0]       rd_count_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   // serial divider, one quotient bit per cycle
   logic [VAL_W-1:0] div_quo_ff;
   logic [CNT_W-1:0] div_rem_ff, div_den_ff;
   logic [5:0]       div_cnt_ff;
   logic             div_run_ff, div_neg_ff;
   logic [CNT_W:0]   div_sh, div_sub;
   logic             div_ge;
   logic [VAL_W-1:0] div_q;

   // ram ports
   logic                  smp_we;
   logic [SAMPLE_AW-1:0]  smp_addr;
   logic [15:0]           smp_rdata;
   logic                  lab_we;
   logic [LABEL_AW-1:0]   lab_addr;
   logic [3:0]            lab_rdata;
   logic                  mean_we;
   logic [MEAN_AW-1:0]    mean_addr;
   logic [15:0]           mean_wdata, mean_rdata;
   logic                  cov_we;
   logic [COV_AW-1:0]     cov_addr;
   logic [VAL_W-1:0]      cov_wdata, cov_rdata;
   logic                  div_start;
   logic [VAL_W-1:0]      div_num;
   logic [CNT_W-1:0]      div_den;
   logic [DIM_W-1:0]      dev_sel;

   // ---------------- decode of the command in idle ----------------
   logic                  accept;
   logic [CIDX_W-1:0]     cnt_idx;
   logic [CNT_W-1:0]      cnt_cur;
   logic [15:0]           add_prod, add_need;
   logic [SAMPLE_AW-1:0]  add_addr;
   logic                  add_range, add_full;
   status_type            add_stat;
   logic                  rd_range;
   status_type            rd_stat;
   logic                  lab_match, s_end, j_last, m_last, c_last;
   logic signed [DEV_W-1:0] dev_rd;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // one read port into the counts: add and read in idle, class during compute
   always_comb begin
      if (state_ff != ST_IDLE) begin
         cnt_idx = c_ff;
      end else if (req_data.func == FUNC_ADD) begin
         cnt_idx = req_data.sample_class[CIDX_W-1:0];
      end else begin
         cnt_idx = req_data.read_class[CIDX_W-1:0];
      end
   end
   assign cnt_cur = counts_ff[cnt_idx];

   assign add_prod  = 16'(sample_total_ff) * 16'(eff_d);
   assign add_need  = (16'(sample_total_ff) + 16'd1) * 16'(eff_d);
   assign add_addr  = add_prod[SAMPLE_AW-1:0] + SAMPLE_AW'(req_data.element_index);
   assign add_range = ({1'b0, req_data.element_index} >= eff_d) ||
                      ({1'b0, req_data.sample_class} >= eff_k);
   assign add_full  = (sample_total_ff >= CNT_W'(MAX_SAMPLES)) ||
                      (add_need > 16'(SAMPLE_DEPTH));
   assign add_stat  = add_range ? STAT_RANGE : (add_full ? STAT_FULL : STAT_OK);

   assign rd_range = ({1'b0, req_data.read_class} >= eff_k) ||
                     ({1'b0, req_data.read_row} >= eff_d) ||
                     ((req_data.read_kind == KIND_COV) && ({1'b0, req_data.read_col} >= eff_d));
   assign rd_stat  = rd_range ? STAT_RANGE :
                     (!results_valid_ff ? STAT_NOT_COMPUTED : STAT_OK);

   assign lab_match = (lab_rdata == 4'(c_ff));
   assign s_end     = (s_ff == sample_total_ff);
   assign j_last    = (j_ff == d_last);
   assign m_last    = (m_ff == d_last);
   assign c_last    = (CFG_W'(c_ff) == eff_k - CFG_W'(1));
   assign dev_rd    = dev_ff[dev_sel];

   // ---------------- divider step ----------------
   assign div_sh  = {div_rem_ff, div_quo_ff[VAL_W-1]};
   assign div_ge  = (div_sh >= {1'b0, div_den_ff});
   assign div_sub = div_sh - {1'b0, div_den_ff};
   assign div_q   = div_neg_ff ? (~div_quo_ff + VAL_W'(1)) : div_quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_run_ff <= 1'b0;
      end else if (div_start) begin
         div_run_ff <= 1'b1;
         div_cnt_ff <= DIV_STEPS;
         div_neg_ff <= div_num[VAL_W-1];
         div_quo_ff <= div_num[VAL_W-1] ? (~div_num + VAL_W'(1)) : div_num;
         div_rem_ff <= '0;
         div_den_ff <= div_den;
      end else if (div_run_ff) begin
         div_quo_ff <= {div_quo_ff[VAL_W-2:0], div_ge};
         div_rem_ff <= div_ge ? div_sub[CNT_W-1:0] : div_sh[CNT_W-1:0];
         div_cnt_ff <= div_cnt_ff - 6'd1;
         if (div_cnt_ff == '0) begin
            div_run_ff <= 1'b0;
         end
      end
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.func == FUNC_COMPUTE)) begin
               state_in = ST_CLS;
            end else if (accept && (req_data.func == FUNC_READ)) begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_IDLE;
         ST_CLS:   state_in = ST_SLAB;
         ST_SLAB:  state_in = s_end ? ST_MGO : ST_SCHK;
         ST_SCHK:  state_in = lab_match ? ST_SRD : ST_SLAB;
         ST_SRD:   state_in = ST_SACC;
         ST_SACC:  state_in = j_last ? ST_SLAB : ST_SRD;
         ST_MGO: begin
            if (cnt_cur != '0) begin
               state_in = ST_MWAIT;
            end else begin
               state_in = j_last ? ST_VLAB : ST_MGO;
            end
         end
         ST_MWAIT: begin
            if (!div_run_ff) begin
               state_in = j_last ? ST_VLAB : ST_MGO;
            end
         end
         ST_VLAB:  state_in = s_end ? ST_NRD : ST_VCHK;
         ST_VCHK:  state_in = lab_match ? ST_VRD : ST_VLAB;
         ST_VRD:   state_in = ST_VDEV;
         ST_VDEV:  state_in = j_last ? ST_VROW : ST_VRD;
         ST_VROW:  state_in = ST_VMRD;
         ST_VMRD:  state_in = ST_VMWR;
         ST_VMWR: begin
            if (!m_last) begin
               state_in = ST_VMRD;
            end else begin
               state_in = j_last ? ST_VLAB : ST_VROW;
            end
         end
         ST_NRD:   state_in = ST_NGO;
         ST_NGO: begin
            if (!first_ff && (cnt_cur > CNT_W'(1))) begin
               state_in = ST_NWAIT;
            end else if (m_last && j_last) begin
               state_in = c_last ? ST_DONE : ST_CLS;
            end else begin
               state_in = ST_NRD;
            end
         end
         ST_NWAIT: begin
            if (!div_run_ff) begin
               if (m_last && j_last) begin
                  state_in = c_last ? ST_DONE : ST_CLS;
               end else begin
                  state_in = ST_NRD;
               end
            end
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------- control outputs ----------------
   always_comb begin
      smp_we     = 1'b0;
      smp_addr   = base_ff + SAMPLE_AW'(j_ff);
      lab_we     = 1'b0;
      lab_addr   = s_ff[LABEL_AW-1:0];
      mean_we    = 1'b0;
      mean_addr  = {c_ff, j_ff};
      mean_wdata = div_q[15:0];
      cov_we     = 1'b0;
      cov_addr   = {c_ff, j_ff, m_ff};
      cov_wdata  = div_q;
      div_start  = 1'b0;
      div_num    = cov_rdata;
      div_den    = cnt_cur - CNT_W'(1);
      dev_sel    = m_ff;
      case (state_ff)
         ST_IDLE: begin
            // stores written straight at transfer; reads issued for a read item
            smp_addr  = add_addr;
            lab_addr  = sample_total_ff[LABEL_AW-1:0];
            mean_addr = {req_data.read_class[CIDX_W-1:0], req_data.read_row};
            cov_addr  = {req_data.read_class[CIDX_W-1:0], req_data.read_row,
                         req_data.read_col};
            if (accept && (req_data.func == FUNC_ADD) && (add_stat == STAT_OK)) begin
               smp_we = 1'b1;
               lab_we = req_data.last_element;
            end
         end
         ST_MGO: begin
            if (cnt_cur == '0) begin
               mean_we    = 1'b1;
               mean_wdata = '0;
            end else begin
               div_start = 1'b1;
               div_num   = {{(VAL_W-SUM_W){sums_ff[j_ff][SUM_W-1]}}, sums_ff[j_ff]};
               div_den   = cnt_cur;
            end
         end
         ST_MWAIT: begin
            mean_we = !div_run_ff;
         end
         ST_VROW: begin
            dev_sel = j_ff;
         end
         ST_VMWR: begin
            cov_we    = 1'b1;
            cov_wdata = (first_ff ? '0 : cov_rdata) +
                        {{(VAL_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
         end
         ST_NGO: begin
            if (first_ff) begin
               // class with no samples: entry set to zero
               cov_we    = 1'b1;
               cov_wdata = '0;
            end else if (cnt_cur > CNT_W'(1)) begin
               div_start = 1'b1;
            end
         end
         ST_NWAIT: begin
            cov_we = !div_run_ff;
         end
         default: begin
         end
      endcase
   end

   // ---------------- datapath ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         sample_total_ff  <= '0;
         results_valid_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < NCLS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               rsp_ff.read_value       <= '0;
               rsp_ff.samples_in_class <= '0;
               rsp_ff.status           <= STAT_OK;
               if (accept) begin
                  case (req_data.func)
                     FUNC_ADD: begin
                        results_valid_ff <= 1'b0;
                        rsp_valid_ff     <= 1'b1;
                        rsp_ff.status    <= add_stat;
                        if ((add_stat == STAT_OK) && req_data.last_element) begin
                           sample_total_ff    <= sample_total_ff + CNT_W'(1);
                           counts_ff[cnt_idx] <= cnt_cur + CNT_W'(1);
                        end
                     end
                     FUNC_COMPUTE: begin
                        c_ff <= '0;
                     end
                     FUNC_READ: begin
                        rd_kind_ff  <= req_data.read_kind;
                        rd_stat_ff  <= rd_stat;
                        rd_count_ff <= rd_range ? '0 : cnt_cur;
                     end
                     FUNC_CLEAR: begin
                        sample_total_ff  <= '0;
                        results_valid_ff <= 1'b0;
                        rsp_valid_ff     <= 1'b1;
                        for (int i = 0; i < NCLS; i++) begin
                           counts_ff[i] <= '0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_READ: begin
               rsp_valid_ff            <= 1'b1;
               rsp_ff.samples_in_class <= rd_count_ff;
               rsp_ff.status           <= rd_stat_ff;
               if (rd_stat_ff != STAT_OK) begin
                  rsp_ff.read_value <= '0;
               end else if (rd_kind_ff == KIND_COV) begin
                  rsp_ff.read_value <= cov_rdata;
               end else begin
                  rsp_ff.read_value <= {{(VAL_W-16){mean_rdata[15]}}, mean_rdata};
               end
            end
            ST_CLS: begin
               s_ff     <= '0;
               base_ff  <= '0;
               j_ff     <= '0;
               first_ff <= 1'b1;
               for (int i = 0; i < MAX_DIM; i++) begin
                  sums_ff[i] <= '0;
               end
            end
            ST_SLAB, ST_VLAB: begin
               j_ff <= '0;
               m_ff <= '0;
               if (s_end) begin
                  s_ff    <= '0;
                  base_ff <= '0;
               end
            end
            ST_SCHK, ST_VCHK: begin
               if (!lab_match) begin
                  s_ff    <= s_ff + CNT_W'(1);
                  base_ff <= base_ff + SAMPLE_AW'(eff_d);
               end
            end
            ST_SACC: begin
               sums_ff[j_ff] <= sums_ff[j_ff] +
                                {{(SUM_W-16){smp_rdata[15]}}, smp_rdata};
               if (j_last) begin
                  s_ff    <= s_ff + CNT_W'(1);
                  base_ff <= base_ff + SAMPLE_AW'(eff_d);
               end else begin
                  j_ff <= j_ff + DIM_W'(1);
               end
            end
            ST_MGO: begin
               if (cnt_cur == '0) begin
                  mean_r_ff[j_ff] <= '0;
                  j_ff <= j_ff + DIM_W'(1);
               end
            end
            ST_MWAIT: begin
               if (!div_run_ff) begin
                  mean_r_ff[j_ff] <= div_q[15:0];
                  j_ff <= j_ff + DIM_W'(1);
               end
            end
            ST_VDEV: begin
               dev_ff[j_ff] <= {smp_rdata[15], smp_rdata} -
                               {mean_r_ff[j_ff][15], mean_r_ff[j_ff]};
               j_ff <= j_last ? '0 : j_ff + DIM_W'(1);
               m_ff <= '0;
            end
            ST_VROW: begin
               devj_ff <= dev_rd;
            end
            ST_VMRD: begin
               prod_ff <= devj_ff * dev_rd;
            end
            ST_VMWR: begin
               if (!m_last) begin
                  m_ff <= m_ff + DIM_W'(1);
               end else begin
                  m_ff <= '0;
                  if (j_last) begin
                     first_ff <= 1'b0;
                     s_ff     <= s_ff + CNT_W'(1);
                     base_ff  <= base_ff + SAMPLE_AW'(eff_d);
                  end else begin
                     j_ff <= j_ff + DIM_W'(1);
                  end
               end
            end
            ST_NGO, ST_NWAIT: begin
               // step to the next entry once this one is settled
               if ((state_ff == ST_NWAIT && !div_run_ff) ||
                   (state_ff == ST_NGO && (first_ff || cnt_cur <= CNT_W'(1)))) begin
                  if (m_last) begin
                     m_ff <= '0;
                     if (j_last) begin
                        c_ff <= c_ff + CIDX_W'(1);
                     end else begin
                        j_ff <= j_ff + DIM_W'(1);
                     end
                  end else begin
                     m_ff <= m_ff + DIM_W'(1);
                  end
               end
            end
            ST_DONE: begin
               results_valid_ff        <= 1'b1;
               rsp_valid_ff            <= 1'b1;
               rsp_ff.read_value       <= '0;
               rsp_ff.samples_in_class <= '0;
               rsp_ff.status           <= STAT_OK;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- stores ----------------
   cmc_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
      .clock (clock),
      .we    (smp_we),
      .addr  (smp_addr),
      .wdata (req_data.element_value),
      .rdata (smp_rdata)
   );

   cmc_ram #(.WIDTH(4), .DEPTH(MAX_SAMPLES)) u_label_ram (
      .clock (clock),
      .we    (lab_we),
      .addr  (lab_addr),
      .wdata (req_data.sample_class),
      .rdata (lab_rdata)
   );

   cmc_ram #(.WIDTH(16), .DEPTH(2 ** MEAN_AW)) u_mean_ram (
      .clock (clock),
      .we    (mean_we),
      .addr  (mean_addr),
      .wdata (mean_wdata),
      .rdata (mean_rdata)
   );

   cmc_ram #(.WIDTH(VAL_W), .DEPTH(2 ** COV_AW)) u_cov_ram (
      .clock (clock),
      .we    (cov_we),
      .addr  (cov_addr),
      .wdata (cov_wdata),
      .rdata (cov_rdata)
   );

   // ---------------- assertions ----------------
   // every transfer gives a result next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("transfer neither answered nor in progress");

   // end of compute answers and marks the results valid
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (rsp_valid && results_valid_ff))
      else $error("compute finished without result");

   // the divider only runs while the sequencer waits on it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_run_ff |-> ((state_ff == ST_MWAIT) || (state_ff == ST_NWAIT)))
      else $error("divider running outside a wait state");

   // the label store never overfills
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      sample_total_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample total beyond store");

endmodule

// File: rtl/cmc_ram.sv
// ---------------------------------------------------------------------------
// cmc_ram
// generic single-port ram with registered read
// ---------------------------------------------------------------------------
module cmc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
